// ----- hdl/text_console_cursor_engine_top_defines.svh -----
// Assertion macros shared by the console cursor engine RTL.
// Included by every module that carries concurrent assertions.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console cursor engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console cursor engine: next-cycle check failed");

`endif

// ----- hdl/tcce_pkg.sv -----
// Package for the console cursor engine: command and draw codes, result types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

    // Command codes on the func field.
    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_SET   = 2'd2,
        FUNC_RSVD  = 2'd3
    } func_t;

    // Draw operation codes sent downstream.
    typedef enum logic [2:0] {
        OP_FILL   = 3'd0,
        OP_GLYPH  = 3'd1,
        OP_SCROLL = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_NONE   = 3'd4
    } draw_op_t;

    // Control characters interpreted by a put request.
    localparam logic [7:0] CHAR_BS = 8'd8;
    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    // Register map (word index into the APB space).
    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_BG   = 2'd2;

    localparam int         ADDR_W       = 4;
    localparam int         DATA_W       = 32;
    localparam logic [7:0] COLS_RESET   = 8'd80;
    localparam logic [7:0] ROWS_RESET   = 8'd25;
    localparam logic [7:0] COLS_MIN     = 8'd2;
    localparam logic [7:0] ROWS_MIN     = 8'd1;

    // A request produces at most this many draw results.
    localparam int RUN_MAX   = 3;
    localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);

    // Configuration seen by the cursor logic.
    typedef struct packed {
        logic [7:0]  cols;
        logic [7:0]  rows;
        logic [23:0] bg_rgb;
    } cfg_t;

    // One draw result.
    typedef struct packed {
        draw_op_t    op;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [7:0]  code;
        logic [23:0] rgb;
        logic        last;
    } res_t;

    // All results of one request, slot 0 delivered first.
    typedef struct packed {
        res_t [RUN_MAX-1:0]   slot;
        logic [RUN_CNT_W-1:0] count;
    } run_t;

    // Build a result with the last flag cleared.
    function automatic res_t mk_res(draw_op_t op, logic [7:0] row, logic [7:0] col,
                                    logic [7:0] code, logic [23:0] rgb);
        res_t r;
        r.op   = op;
        r.row  = row;
        r.col  = col;
        r.code = code;
        r.rgb  = rgb;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tcce_cfg_regs.sv -----
// APB register file of the console cursor engine: columns, rows, background.
// Depends on tcce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcce_cfg_regs
    import tcce_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [7:0]  cols_reg;
    logic [7:0]  rows_reg;
    logic [23:0] bg_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes on the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
            bg_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_COLS: cols_reg <= pwdata[7:0];
                REG_ROWS: rows_reg <= pwdata[7:0];
                REG_BG:   bg_reg   <= pwdata[23:0];
                default:  ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_COLS: prdata = {24'd0, cols_reg};
            REG_ROWS: prdata = {24'd0, rows_reg};
            REG_BG:   prdata = {8'd0, bg_reg};
            default:  prdata = '0;
        endcase
    end

    assign cfg.cols   = cols_reg;
    assign cfg.rows   = rows_reg;
    assign cfg.bg_rgb = bg_reg;

endmodule

`default_nettype wire

// ----- hdl/tcce_cursor_core.sv -----
// Input register, cursor state and the single-pass logic that turns one
// request into its run of draw results. Depends on tcce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcce_cursor_core
    import tcce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  char_code,
    input  wire logic [23:0] glyph_rgb,
    input  wire logic [7:0]  target_row,
    input  wire logic [7:0]  target_col,
    output logic             run_valid,
    input  wire logic        run_ready,
    output run_t             run
);

    typedef struct packed {
        func_t       func;
        logic [7:0]  code;
        logic [23:0] fg;
        logic [7:0]  trow;
        logic [7:0]  tcol;
    } req_t;

    req_t        req_reg;
    logic        req_valid_reg;
    logic        req_valid_next;
    logic [7:0]  row_reg;
    logic [7:0]  row_next;
    logic [7:0]  col_reg;
    logic [7:0]  col_next;
    logic        take_req;
    logic        advance;

    logic [7:0]  cols_eff;
    logic [7:0]  rows_eff;
    logic [8:0]  nl_row9;
    logic        nl_scroll;
    logic [7:0]  nl_row;
    logic [8:0]  col_inc9;
    logic        wrap;
    res_t        scroll_res;
    res_t        none_res;
    run_t        run_calc;

    assign take_req  = cmd_valid && cmd_ready;
    assign advance   = req_valid_reg && run_ready;
    assign cmd_ready = !req_valid_reg || run_ready;
    assign run_valid = req_valid_reg;

    // Request holding register.
    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            req_reg.func <= func_t'(func);
            req_reg.code <= char_code;
            req_reg.fg   <= glyph_rgb;
            req_reg.trow <= target_row;
            req_reg.tcol <= target_col;
        end
    end

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (take_req)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
    end

    // Control state: request valid and cursor position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            if (advance)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    // Geometry with degenerate register values raised to the minimum.
    assign cols_eff = (cfg.cols < COLS_MIN) ? COLS_MIN : cfg.cols;
    assign rows_eff = (cfg.rows < ROWS_MIN) ? ROWS_MIN : cfg.rows;

    // Line feed from the current row; scrolls when it runs past the last row.
    assign nl_row9   = {1'b0, row_reg} + 9'd1;
    assign nl_scroll = nl_row9 >= {1'b0, rows_eff};
    assign nl_row    = nl_scroll ? (rows_eff - 8'd1) : nl_row9[7:0];

    // Column advance after a glyph; wraps one column before the end.
    assign col_inc9 = {1'b0, col_reg} + 9'd1;
    assign wrap     = ({1'b0, col_inc9} + 10'd1) >= {2'b0, cols_eff};

    assign scroll_res = mk_res(OP_SCROLL, rows_eff - 8'd1, 8'd0, 8'd0, cfg.bg_rgb);
    assign none_res   = mk_res(OP_NONE, 8'd0, 8'd0, 8'd0, 24'd0);

    // Decode the request into its results and the next cursor.
    always_comb
    begin
        run_calc.slot  = {RUN_MAX{none_res}};
        run_calc.count = RUN_CNT_W'(1);
        row_next       = row_reg;
        col_next       = col_reg;

        unique case (req_reg.func)
            FUNC_PUT:
            begin
                case (req_reg.code)
                    CHAR_LF:
                    begin
                        row_next = nl_row;
                        col_next = '0;
                        if (nl_scroll)
                        begin
                            run_calc.slot[0] = scroll_res;
                        end
                    end
                    CHAR_CR:
                    begin
                        col_next = '0;
                    end
                    CHAR_BS:
                    begin
                        if (col_reg != 8'd0)
                        begin
                            col_next = col_reg - 8'd1;
                        end
                        else if (row_reg != 8'd0)
                        begin
                            col_next = cols_eff - 8'd2;
                            row_next = row_reg - 8'd1;
                        end
                        run_calc.slot[0] = mk_res(OP_FILL, row_next, col_next, 8'd0,
                                                  cfg.bg_rgb);
                    end
                    default:
                    begin
                        run_calc.slot[0] = mk_res(OP_FILL, row_reg, col_reg, 8'd0,
                                                  cfg.bg_rgb);
                        run_calc.slot[1] = mk_res(OP_GLYPH, row_reg, col_reg,
                                                  req_reg.code, req_reg.fg);
                        run_calc.count   = RUN_CNT_W'(2);
                        col_next         = col_inc9[7:0];
                        if (wrap)
                        begin
                            row_next = nl_row;
                            col_next = '0;
                            if (nl_scroll)
                            begin
                                run_calc.slot[2] = scroll_res;
                                run_calc.count   = RUN_CNT_W'(3);
                            end
                        end
                    end
                endcase
            end
            FUNC_CLEAR:
            begin
                run_calc.slot[0] = mk_res(OP_CLEAR, 8'd0, 8'd0, 8'd0, cfg.bg_rgb);
                row_next         = '0;
                col_next         = '0;
            end
            FUNC_SET:
            begin
                row_next = (req_reg.trow > cfg.rows) ? cfg.rows : req_reg.trow;
                col_next = (req_reg.tcol > cfg.cols) ? cfg.cols : req_reg.tcol;
            end
            default: ;
        endcase

        // Flag the final result of the run.
        for (int i = 0; i < RUN_MAX; i++)
        begin
            run_calc.slot[i].last = (RUN_CNT_W'(i) == (run_calc.count - RUN_CNT_W'(1)));
        end
    end

    assign run = run_calc;

endmodule

`default_nettype wire

// ----- hdl/tcce_run_emitter.sv -----
// Result buffer that holds one run of draw results and hands them out one
// per cycle over the draw channel while draw_ready is high. Depends on tcce_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_cursor_engine_top_defines.svh"

module tcce_run_emitter
    import tcce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        run_valid,
    output logic             run_ready,
    input  wire run_t        run,
    output logic             draw_valid,
    input  wire logic        draw_ready,
    output res_t             draw_res
);

    res_t                 slot_reg [RUN_MAX];
    logic [RUN_CNT_W-1:0] count_reg;
    logic [RUN_CNT_W-1:0] count_next;
    logic                 take;
    logic                 load;

    assign draw_valid = count_reg != '0;
    assign take       = draw_valid && draw_ready;
    // A new run fits once the buffer is empty or its last result leaves now.
    assign run_ready  = (count_reg == '0) || (count_reg == RUN_CNT_W'(1) && draw_ready);
    assign load       = run_valid && run_ready;

    always_comb
    begin
        count_next = count_reg;
        if (load)
        begin
            count_next = run.count;
        end
        else if (take)
        begin
            count_next = count_reg - RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Slot 0 is the output register; the rest shift down as results leave.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < RUN_MAX; i++)
            begin
                slot_reg[i] <= run.slot[i];
            end
        end
        else if (take)
        begin
            for (int i = 0; i < RUN_MAX - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

    assign draw_res = slot_reg[0];

    // The presented result is flagged last exactly when it is the only one left.
    `TCCE_ASSERT_IMPLY(a_last_at_tail, clk, rst_n, draw_valid, slot_reg[0].last == (count_reg == RUN_CNT_W'(1)))
    // A result taken from a longer run leaves the next one on the channel.
    `TCCE_ASSERT_NEXT(a_run_continues, clk, rst_n, take && (count_reg > RUN_CNT_W'(1)), draw_valid)
    // A loaded run keeps all of its results.
    `TCCE_ASSERT_NEXT(a_load_count, clk, rst_n, load, count_reg == $past(run.count))

endmodule

`default_nettype wire

// ----- hdl/text_console_cursor_engine_top.sv -----
// Text console cursor engine: turns console requests into cell draw results.
// An accepted request is registered, decoded combinationally against the cursor
// and the configuration, and its one to three results are loaded into a
// result buffer that presents them one per cycle on the draw channel while
// draw_ready is high. The cursor moves as the request is decoded, so requests
// follow back to back. The draw channel sets the pace: a request has one
// result for newline, return, backspace, clear, set cursor and unused codes,
// two for a printed character and three when that character wraps into a
// scroll. The first result is presented once the request has passed the
// request register and has been loaded into the result buffer.
// Depends on tcce_pkg, tcce_cfg_regs, tcce_cursor_core and tcce_run_emitter.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_engine_top
    import tcce_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    // Request channel
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire logic [1:0]        func,
    input  wire logic [7:0]        char_code,
    input  wire logic [23:0]       glyph_rgb,
    input  wire logic [7:0]        target_row,
    input  wire logic [7:0]        target_col,
    // Draw channel
    output logic                   draw_valid,
    input  wire logic              draw_ready,
    output logic [2:0]             draw_op,
    output logic [7:0]             cell_row,
    output logic [7:0]             cell_col,
    output logic [7:0]             glyph_code,
    output logic [23:0]            paint_rgb,
    output logic                   last_of_run
);

    cfg_t cfg;
    run_t run;
    logic run_valid;
    logic run_ready;
    res_t draw_res;

    // Configuration registers.
    tcce_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Request register, cursor and decode.
    tcce_cursor_core u_cursor_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .func       (func),
        .char_code  (char_code),
        .glyph_rgb  (glyph_rgb),
        .target_row (target_row),
        .target_col (target_col),
        .run_valid  (run_valid),
        .run_ready  (run_ready),
        .run        (run)
    );

    // Result buffer and draw channel.
    tcce_run_emitter u_run_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .run_valid  (run_valid),
        .run_ready  (run_ready),
        .run        (run),
        .draw_valid (draw_valid),
        .draw_ready (draw_ready),
        .draw_res   (draw_res)
    );

    assign draw_op     = draw_res.op;
    assign cell_row    = draw_res.row;
    assign cell_col    = draw_res.col;
    assign glyph_code  = draw_res.code;
    assign paint_rgb   = draw_res.rgb;
    assign last_of_run = draw_res.last;

endmodule

`default_nettype wire

// ----- verif/tcce_checker.sv -----
// Checker for the console cursor engine: tracks register writes, checks reads, predicts the draw
// results of every accepted request and compares them with the draw channel.
// Depends on tcce_pkg for the command, draw and register codes.
`timescale 1ns / 1ps

module tcce_checker
    import tcce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    input  logic              cmd_valid,
    input  logic              cmd_ready,
    input  logic [1:0]        func,
    input  logic [7:0]        char_code,
    input  logic [23:0]       glyph_rgb,
    input  logic [7:0]        target_row,
    input  logic [7:0]        target_col,
    input  logic              draw_valid,
    input  logic              draw_ready,
    input  logic [2:0]        draw_op,
    input  logic [7:0]        cell_row,
    input  logic [7:0]        cell_col,
    input  logic [7:0]        glyph_code,
    input  logic [23:0]       paint_rgb,
    input  logic              last_of_run,
    output int                fail_count,
    output int                pending_draws,
    output int                draws_checked
);

    // Shadow copy of the registers and the cursor.
    logic [7:0]  cfg_cols;
    logic [7:0]  cfg_rows;
    logic [23:0] cfg_bg;
    logic [7:0]  cur_row;
    logic [7:0]  cur_col;

    // Draw results still owed by the block, oldest first.
    res_t draw_expect_q[$];

    // Geometry as the cursor logic sees it, with degenerate sizes raised.
    function automatic int cols_in_use();
        return (cfg_cols < COLS_MIN) ? int'(COLS_MIN) : int'(cfg_cols);
    endfunction

    function automatic int rows_in_use();
        return (cfg_rows < ROWS_MIN) ? int'(ROWS_MIN) : int'(cfg_rows);
    endfunction

    function automatic res_t draw_entry(draw_op_t op, logic [7:0] row, logic [7:0] col,
                                        logic [7:0] code, logic [23:0] rgb);
        res_t e;
        e.op   = op;
        e.row  = row;
        e.col  = col;
        e.code = code;
        e.rgb  = rgb;
        e.last = 1'b0;
        return e;
    endfunction

    // Move to the start of the next line; returns 1 when the screen scrolls.
    function automatic logic line_feed();
        int next_row;
        next_row = int'(cur_row) + 1;
        cur_col = 8'd0;
        if (next_row >= rows_in_use()) begin
            cur_row = 8'(rows_in_use() - 1);
            return 1'b1;
        end
        cur_row = 8'(next_row);
        return 1'b0;
    endfunction

    // Work out the draw results of one request and queue them.
    task automatic predict_request(input logic [1:0] f, input logic [7:0] ch,
                                   input logic [23:0] fg, input logic [7:0] tr,
                                   input logic [7:0] tc);
        res_t run [RUN_MAX];
        int   n;
        int   next_col;
        n = 0;
        case (f)
            FUNC_PUT: begin
                if (ch == CHAR_LF) begin
                    if (line_feed()) begin
                        run[n] = draw_entry(OP_SCROLL, cur_row, 8'd0, 8'd0, cfg_bg);
                        n = n + 1;
                    end
                end else if (ch == CHAR_CR) begin
                    cur_col = 8'd0;
                end else if (ch == CHAR_BS) begin
                    // Step back; from column 0 wrap to the row above, stay at the origin.
                    if (cur_col > 8'd0) begin
                        cur_col = cur_col - 8'd1;
                    end else if (cur_row > 8'd0) begin
                        cur_col = 8'(cols_in_use() - 2);
                        cur_row = cur_row - 8'd1;
                    end
                    run[n] = draw_entry(OP_FILL, cur_row, cur_col, 8'd0, cfg_bg);
                    n = n + 1;
                end else begin
                    // Printed character: blank the cell, draw, then advance or wrap.
                    run[0] = draw_entry(OP_FILL, cur_row, cur_col, 8'd0, cfg_bg);
                    run[1] = draw_entry(OP_GLYPH, cur_row, cur_col, ch, fg);
                    n = 2;
                    next_col = int'(cur_col) + 1;
                    if (next_col + 1 >= cols_in_use()) begin
                        if (line_feed()) begin
                            run[n] = draw_entry(OP_SCROLL, cur_row, 8'd0, 8'd0, cfg_bg);
                            n = n + 1;
                        end
                    end else begin
                        cur_col = 8'(next_col);
                    end
                end
            end
            FUNC_CLEAR: begin
                run[n] = draw_entry(OP_CLEAR, 8'd0, 8'd0, 8'd0, cfg_bg);
                n = n + 1;
                cur_row = 8'd0;
                cur_col = 8'd0;
            end
            FUNC_SET: begin
                // The clamp uses the raw register values and admits the limit itself.
                cur_row = (tr > cfg_rows) ? cfg_rows : tr;
                cur_col = (tc > cfg_cols) ? cfg_cols : tc;
            end
            default: begin
            end
        endcase
        if (n == 0) begin
            run[0] = draw_entry(OP_NONE, 8'd0, 8'd0, 8'd0, 24'd0);
            n = 1;
        end
        run[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) begin
            draw_expect_q.push_back(run[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        res_t        want;
        logic [31:0] reg_value;
        if (!rst_n) begin
            cfg_cols      = COLS_RESET;
            cfg_rows      = ROWS_RESET;
            cfg_bg        = 24'd0;
            cur_row       = 8'd0;
            cur_col       = 8'd0;
            fail_count    = 0;
            draws_checked = 0;
            draw_expect_q.delete();
            pending_draws = 0;
        end else begin
            // Draw channel: compare with the oldest expectation.
            if (draw_valid && draw_ready) begin
                draws_checked = draws_checked + 1;
                if (draw_expect_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("[%0t] unexpected draw result op=%0d row=%0d col=%0d",
                                 $realtime, draw_op, cell_row, cell_col);
                    fail_count = fail_count + 1;
                end else begin
                    want = draw_expect_q.pop_front();
                    if (draw_op !== want.op || cell_row !== want.row ||
                        cell_col !== want.col || glyph_code !== want.code ||
                        paint_rgb !== want.rgb || last_of_run !== want.last) begin
                        if (fail_count < 10) begin
                            $display("[%0t] draw mismatch: expected op=%0d row=%0d col=%0d code=%02h rgb=%06h last=%0b",
                                     $realtime, want.op, want.row, want.col, want.code,
                                     want.rgb, want.last);
                            $display("               got      op=%0d row=%0d col=%0d code=%02h rgb=%06h last=%0b",
                                     draw_op, cell_row, cell_col, glyph_code, paint_rgb,
                                     last_of_run);
                        end
                        fail_count = fail_count + 1;
                    end
                end
            end

            // Request channel: predict from the state before this request.
            if (cmd_valid && cmd_ready)
                predict_request(func, char_code, glyph_rgb, target_row, target_col);

            // Configuration port: register reads are checked, writes update the shadow.
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_COLS: cfg_cols = pwdata[7:0];
                        REG_ROWS: cfg_rows = pwdata[7:0];
                        REG_BG:   cfg_bg   = pwdata[23:0];
                        default: begin
                        end
                    endcase
                end else if (paddr[3:2] != 2'd3) begin
                    case (paddr[3:2])
                        REG_COLS: reg_value = {24'd0, cfg_cols};
                        REG_ROWS: reg_value = {24'd0, cfg_rows};
                        default:  reg_value = {8'd0, cfg_bg};
                    endcase
                    if (prdata !== reg_value) begin
                        if (fail_count < 10)
                            $display("[%0t] register read at %0h: expected %08h got %08h",
                                     $realtime, paddr, reg_value, prdata);
                        fail_count = fail_count + 1;
                    end
                end
            end

            pending_draws = draw_expect_q.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// Top of the console cursor engine testbench: clock, reset, request and register
// stimulus, draw channel back-pressure, watchdog and verdict.
// Depends on tcce_pkg, text_console_cursor_engine_top and tcce_checker.
`timescale 1ns / 1ps

module tb;
    import tcce_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              cmd_valid;
    logic              cmd_ready;
    logic [1:0]        func;
    logic [7:0]        char_code;
    logic [23:0]       glyph_rgb;
    logic [7:0]        target_row;
    logic [7:0]        target_col;
    logic              draw_valid;
    logic              draw_ready;
    logic [2:0]        draw_op;
    logic [7:0]        cell_row;
    logic [7:0]        cell_col;
    logic [7:0]        glyph_code;
    logic [23:0]       paint_rgb;
    logic              last_of_run;

    int fail_count;
    int pending_draws;
    int draws_checked;

    int burst_left     = 0;
    int requests_sent  = 0;
    int settings_used  = 0;
    int idle_cycles    = 0;
    int rx_mode        = 0;
    int rx_mode_left   = 0;
    int rx_hold        = 0;
    logic [7:0] cols_now = COLS_RESET;
    logic [7:0] rows_now = ROWS_RESET;

    text_console_cursor_engine_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .func        (func),
        .char_code   (char_code),
        .glyph_rgb   (glyph_rgb),
        .target_row  (target_row),
        .target_col  (target_col),
        .draw_valid  (draw_valid),
        .draw_ready  (draw_ready),
        .draw_op     (draw_op),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .glyph_code  (glyph_code),
        .paint_rgb   (paint_rgb),
        .last_of_run (last_of_run)
    );

    tcce_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .func          (func),
        .char_code     (char_code),
        .glyph_rgb     (glyph_rgb),
        .target_row    (target_row),
        .target_col    (target_col),
        .draw_valid    (draw_valid),
        .draw_ready    (draw_ready),
        .draw_op       (draw_op),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .glyph_code    (glyph_code),
        .paint_rgb     (paint_rgb),
        .last_of_run   (last_of_run),
        .fail_count    (fail_count),
        .pending_draws (pending_draws),
        .draws_checked (draws_checked)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Draw channel back-pressure, drawn from one of four stall modes that change at random.
    always @(negedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(30, 120);
        end
        rx_mode_left = rx_mode_left - 1;
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
        end else begin
            case (rx_mode)
                0: draw_ready = 1'b1;
                1: draw_ready = ($urandom_range(0, 1) == 1);
                2: begin
                    draw_ready = !draw_ready;
                    rx_hold    = draw_ready ? $urandom_range(0, 3) : $urandom_range(0, 14);
                end
                default: draw_ready = ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog on cycles in which neither channel accepts anything.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((cmd_valid && cmd_ready) || (draw_valid && draw_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Offer one request, honoring the burst and gap pattern; returns at a falling edge.
    task automatic send_request(input logic [1:0] f, input logic [7:0] ch,
                                input logic [23:0] fg, input logic [7:0] tr,
                                input logic [7:0] tc);
        if (burst_left == 0) begin
            cmd_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left = burst_left - 1;
        cmd_valid  = 1'b1;
        func       = f;
        char_code  = ch;
        glyph_rgb  = fg;
        target_row = tr;
        target_col = tc;
        @(posedge clk);
        while (!(cmd_valid && cmd_ready)) @(posedge clk);
        requests_sent = requests_sent + 1;
        @(negedge clk);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic is_write, input logic [1:0] idx,
                              input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Let every owed draw result arrive, then let the pipeline settle.
    task automatic wait_drained();
        cmd_valid = 1'b0;
        while (pending_draws != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Program a new screen geometry and background while the block is idle.
    task automatic set_screen(input logic [7:0] cols, input logic [7:0] rows,
                              input logic [23:0] bg);
        wait_drained();
        apb_access(1'b1, REG_COLS, {24'd0, cols});
        apb_access(1'b1, REG_ROWS, {24'd0, rows});
        apb_access(1'b1, REG_BG, {8'd0, bg});
        apb_access(1'b0, REG_COLS, 32'd0);
        apb_access(1'b0, REG_ROWS, 32'd0);
        apb_access(1'b0, REG_BG, 32'd0);
        cols_now      = cols;
        rows_now      = rows;
        settings_used = settings_used + 1;
    endtask

    // Random request, weighted toward printed text with control characters mixed in.
    task automatic send_random_request();
        int          pick;
        logic [1:0]  f;
        logic [7:0]  ch;
        logic [7:0]  tr;
        logic [7:0]  tc;
        logic [23:0] fg;
        pick = $urandom_range(0, 99);
        f    = FUNC_PUT;
        ch   = 8'($urandom);
        fg   = 24'($urandom);
        tr   = 8'($urandom);
        tc   = 8'($urandom);
        if (pick < 55) begin
            f = FUNC_PUT;
        end else if (pick < 67) begin
            ch = CHAR_LF;
        end else if (pick < 73) begin
            ch = CHAR_CR;
        end else if (pick < 83) begin
            ch = CHAR_BS;
        end else if (pick < 91) begin
            f = FUNC_SET;
            // Half of the targets land around the limits so the clamp is exercised.
            if ($urandom_range(0, 1) == 1) begin
                tr = (rows_now == 8'hFF) ? 8'hFF
                                         : 8'($urandom_range(0, int'(rows_now) + 1));
                tc = (cols_now == 8'hFF) ? 8'hFF
                                         : 8'($urandom_range(0, int'(cols_now) + 1));
            end
        end else if (pick < 94) begin
            f = FUNC_CLEAR;
        end else if (pick < 97) begin
            f = FUNC_RSVD;
        end else begin
            f = 2'($urandom);
        end
        send_request(f, ch, fg, tr, tc);
    endtask

    initial begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cmd_valid  = 1'b0;
        func       = FUNC_PUT;
        char_code  = 8'd0;
        glyph_rgb  = 24'd0;
        target_row = 8'd0;
        target_col = 8'd0;
        draw_ready = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset values of the registers.
        apb_access(1'b0, REG_COLS, 32'd0);
        apb_access(1'b0, REG_ROWS, 32'd0);
        apb_access(1'b0, REG_BG, 32'd0);

        // Directed: default 80 x 25 screen.
        send_request(FUNC_PUT, 8'h41, 24'hFFFFFF, 8'd0, 8'd0);
        send_request(FUNC_PUT, 8'h00, 24'h000000, 8'hFF, 8'hFF);
        send_request(FUNC_PUT, 8'hFF, 24'hA5A5A5, 8'd0, 8'd0);
        send_request(FUNC_PUT, CHAR_CR, 24'd0, 8'd0, 8'd0);
        send_request(FUNC_PUT, CHAR_BS, 24'd0, 8'd0, 8'd0);      // backspace at the origin
        send_request(FUNC_PUT, CHAR_LF, 24'd0, 8'd0, 8'd0);
        send_request(FUNC_PUT, CHAR_BS, 24'd0, 8'd0, 8'd0);      // wrap to the row above
        send_request(FUNC_SET, 8'd0, 24'd0, 8'hFF, 8'hFF);       // clamp to the limits
        send_request(FUNC_PUT, CHAR_LF, 24'd0, 8'd0, 8'd0);      // newline below the screen
        send_request(FUNC_RSVD, 8'h5A, 24'h123456, 8'h33, 8'h44);
        send_request(FUNC_CLEAR, 8'd0, 24'd0, 8'd0, 8'd0);

        // Directed: smallest legal screen, every character wraps and scrolls.
        set_screen(8'd2, 8'd1, 24'hFFFFFF);
        send_request(FUNC_PUT, 8'h78, 24'h00FF00, 8'd0, 8'd0);
        send_request(FUNC_PUT, CHAR_BS, 24'd0, 8'd0, 8'd0);
        send_request(FUNC_SET, 8'd0, 24'd0, 8'd5, 8'd5);
        send_request(FUNC_PUT, 8'h7E, 24'hFF0000, 8'd0, 8'd0);
        send_request(FUNC_PUT, CHAR_LF, 24'd0, 8'd0, 8'd0);

        // Directed: degenerate geometry below the legal minimum.
        set_screen(8'd0, 8'd0, 24'($urandom));
        send_request(FUNC_PUT, 8'h20, 24'h0000FF, 8'd0, 8'd0);
        send_request(FUNC_SET, 8'd0, 24'd0, 8'hFF, 8'hFF);
        send_request(FUNC_PUT, CHAR_BS, 24'd0, 8'd0, 8'd0);
        send_request(FUNC_CLEAR, 8'd0, 24'd0, 8'd0, 8'd0);

        // Directed: largest screen with the cursor at and past the far corner.
        set_screen(8'hFF, 8'hFF, 24'($urandom));
        send_request(FUNC_SET, 8'd0, 24'd0, 8'd254, 8'd254);
        send_request(FUNC_PUT, 8'h31, 24'($urandom), 8'd0, 8'd0);
        send_request(FUNC_SET, 8'd0, 24'd0, 8'hFF, 8'hFF);
        send_request(FUNC_PUT, 8'h32, 24'($urandom), 8'd0, 8'd0);
        send_request(FUNC_PUT, CHAR_BS, 24'd0, 8'd0, 8'd0);

        // Random phases, each under its own screen setting.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_screen(8'($urandom_range(2, 8)), 8'($urandom_range(1, 4)),
                              24'($urandom));
                1: set_screen(8'hFF, 8'hFF, 24'hFFFFFF);
                2: set_screen(8'($urandom_range(0, 1)), 8'd0, 24'd0);
                3: set_screen(8'($urandom_range(2, 16)), 8'($urandom_range(1, 8)),
                              24'($urandom));
                4: set_screen(8'($urandom), 8'($urandom), 24'($urandom));
                default: set_screen(8'd3, 8'd2, 24'($urandom));
            endcase
            for (int k = 0; k < 42; k++) begin
                send_random_request();
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);

        $display("Drove %0d console requests under %0d register settings.",
                 requests_sent, settings_used + 1);
        $display("Checked %0d draw results, including wraps, scrolls and clamped moves.",
                 draws_checked);
        if (fail_count == 0 && pending_draws == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/tcce_pkg.sv
hdl/tcce_cfg_regs.sv
hdl/tcce_cursor_core.sv
hdl/tcce_run_emitter.sv
hdl/text_console_cursor_engine_top.sv
verif/tcce_checker.sv
verif/tb.sv
